@@ design/u8dec_pkg.sv @@
package u8dec_pkg;

    // decode_mode codes; any other code accepts either form
    localparam logic [1:0] ModeStrict   = 2'd0;
    localparam logic [1:0] ModeModified = 2'd1;
    localparam logic [1:0] ModeEither   = 2'd2;

    // decoupling queue between front and back
    localparam int QueueDepth = 4;
    localparam int QueueAw    = $clog2(QueueDepth);

    // one decoded byte: zero, one or two units plus end-of-string status
    typedef struct packed {
        logic [15:0] unit0;
        logic [15:0] unit1;
        logic        two;    // unit0 and unit1 both valid
        logic        has;    // unit0 valid (single-unit job)
        logic        last;   // final byte of the string
        logic        ok;     // string status, meaningful with last
    } t_job;

    // pending count right after the lead byte of a sequence
    function automatic logic [1:0] first_pending(input logic [7:0] lead);
        logic [1:0] r;
        if (lead < 8'hE0)      r = 2'd1;
        else if (lead < 8'hF0) r = 2'd2;
        else                   r = 2'd3;
        return r;
    endfunction

endpackage

@@ design/u8dec_if.sv @@
// Byte channel into the decoder
interface u8dec_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       string_last;

    modport source (output valid, output data_byte, output string_last, input ready);
    modport sink   (input valid, input data_byte, input string_last, output ready);
endinterface

// Code unit channel out of the decoder
interface u8dec_unit_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        unit_present;
    logic        string_end;
    logic        string_ok;
    logic        last_result;

    modport source (output valid, output code_unit, output unit_present,
                    output string_end, output string_ok, output last_result,
                    input ready);
    modport sink   (input valid, input code_unit, input unit_present,
                    input string_end, input string_ok, input last_result,
                    output ready);
endinterface

@@ design/utf8_mutf8_to_utf16_decoder.sv @@
// Channel   Dir  Word                                         Handshake
// i_byte    in   data_byte[8], string_last                    valid/ready
// o_unit    out  code_unit[16], unit_present, string_end,     valid/ready
//                string_ok, last_result
// i_cfg     in   decode_mode[2] on i_cfg_data                 i_cfg_we
//
// One byte per cycle in while the queue has room; one word per cycle out while
// o_unit.ready is high. A byte that closes a 4-byte scalar yields two words.
// A byte passes the front decode, the queue and the output register in that order.
// A 4-entry queue parts the parser from the output stage so each stalls alone.
// Synchronous active-low reset; mode resets to "either form".
module utf8_mutf8_to_utf16_decoder (
    input  logic          i_clk,
    input  logic          i_rst_n,
    u8dec_byte_if.sink    i_byte,
    u8dec_unit_if.source  o_unit,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_data
);
    import u8dec_pkg::*;

    logic w_push, w_pop, w_full, w_empty;
    t_job w_job, w_head;

    u8dec_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte     (i_byte),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_job      (w_job)
    );

    u8dec_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    u8dec_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_unit  (o_unit)
    );

`ifndef ASSERT_OFF
    // no push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full) else $error("queue overflow");

    // no pop from an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty) else $error("queue underflow");

    // end of string only on the last word of a byte
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_unit.valid && o_unit.string_end) |-> o_unit.last_result)
        else $error("string end before last word");

    // a first-of-pair word is always followed by its partner
    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_unit.valid && o_unit.ready && !o_unit.last_result) |=>
        (o_unit.valid && o_unit.unit_present))
        else $error("surrogate pair broken");
`endif

endmodule

@@ design/u8dec_front.sv @@
module u8dec_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    u8dec_byte_if.sink        i_byte,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_data,
    input  logic              i_full,
    output logic              o_push,
    output u8dec_pkg::t_job   o_job
);
    import u8dec_pkg::*;

    logic [1:0]  r_mode;
    logic [1:0]  r_pend, n_pend;
    logic [7:0]  r_lead, n_lead;
    logic [20:0] r_part, n_part;
    logic        r_strict, n_strict;
    logic        r_mod, n_mod;

    logic        w_accept;
    logic [7:0]  w_b;
    logic        w_second;
    logic [19:0] w_sup;
    logic [1:0]  w_cnt;
    logic [15:0] w_u0, w_u1;

    assign i_byte.ready = !i_full;
    assign w_accept     = i_byte.valid && !i_full;
    assign w_b          = i_byte.data_byte;

    // sequence parser and both validators, one byte per cycle while the queue has room
    always_comb begin
        n_strict = r_strict && (r_mode != ModeModified);
        n_mod    = r_mod && (r_mode != ModeStrict);
        n_pend   = r_pend;
        n_lead   = r_lead;
        n_part   = r_part;
        w_cnt    = 2'd0;
        w_u0     = '0;
        w_u1     = '0;
        w_second = (r_pend == first_pending(r_lead));
        w_sup    = '0;
        if (n_strict || n_mod) begin
            if (r_pend == 2'd0) begin
                if (w_b == 8'h00) begin
                    n_mod = 1'b0;
                    if (n_strict) w_cnt = 2'd1;
                end else if (w_b <= 8'h7F) begin
                    w_cnt = 2'd1;
                    w_u0  = {8'h00, w_b};
                end else if (w_b == 8'hC0) begin
                    n_strict = 1'b0;
                    n_lead   = w_b;
                    n_part   = '0;
                    n_pend   = 2'd1;
                end else if (w_b >= 8'hC2 && w_b <= 8'hDF) begin
                    n_lead = w_b;
                    n_part = {16'h0, w_b[4:0]};
                    n_pend = 2'd1;
                end else if (w_b >= 8'hE0 && w_b <= 8'hEF) begin
                    n_lead = w_b;
                    n_part = {17'h0, w_b[3:0]};
                    n_pend = 2'd2;
                end else if (w_b >= 8'hF0 && w_b <= 8'hF4) begin
                    n_mod  = 1'b0;
                    n_lead = w_b;
                    n_part = {18'h0, w_b[2:0]};
                    n_pend = 2'd3;
                end else begin
                    n_strict = 1'b0;
                    n_mod    = 1'b0;
                end
            end else if (w_b < 8'h80 || w_b > 8'hBF) begin
                n_strict = 1'b0;
                n_mod    = 1'b0;
                n_pend   = 2'd0;
            end else begin
                if (r_lead == 8'hC0 && w_b != 8'h80) n_mod = 1'b0;
                if (w_second) begin
                    if (r_lead == 8'hE0 && w_b < 8'hA0) begin
                        n_strict = 1'b0;
                        n_mod    = 1'b0;
                    end
                    if (r_lead == 8'hED && w_b > 8'h9F) n_strict = 1'b0;
                    if (r_lead == 8'hF0 && w_b < 8'h90) n_strict = 1'b0;
                    if (r_lead == 8'hF4 && w_b > 8'h8F) n_strict = 1'b0;
                end
                n_part = {r_part[14:0], w_b[5:0]};
                n_pend = r_pend - 2'd1;
                w_sup  = n_part[19:0] - 20'h10000;
                if (n_pend == 2'd0 && (n_strict || n_mod)) begin
                    if (r_lead >= 8'hF0) begin
                        // supplementary scalar: surrogate pair
                        w_cnt = 2'd2;
                        w_u0  = 16'hD800 + {6'h0, w_sup[19:10]};
                        w_u1  = 16'hDC00 + {6'h0, w_sup[9:0]};
                    end else begin
                        w_cnt = 2'd1;
                        w_u0  = n_part[15:0];
                    end
                end
            end
        end
    end

    // job record for the back end
    always_comb begin
        o_push     = w_accept && (w_cnt != 2'd0 || i_byte.string_last);
        o_job.unit0 = w_u0;
        o_job.unit1 = w_u1;
        o_job.two   = (w_cnt == 2'd2);
        o_job.has   = (w_cnt == 2'd1);
        o_job.last  = i_byte.string_last;
        o_job.ok    = (n_strict || n_mod) && (n_pend == 2'd0);
    end

    // parser state; the final byte of a string re-arms the validators from the mode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= ModeEither;
            r_pend   <= '0;
            r_lead   <= '0;
            r_part   <= '0;
            r_strict <= 1'b1;
            r_mod    <= 1'b1;
        end else begin
            if (i_cfg_we) r_mode <= i_cfg_data;
            if (w_accept) begin
                if (i_byte.string_last) begin
                    r_pend   <= '0;
                    r_lead   <= '0;
                    r_part   <= '0;
                    r_strict <= (r_mode != ModeModified);
                    r_mod    <= (r_mode != ModeStrict);
                end else begin
                    r_pend   <= n_pend;
                    r_lead   <= n_lead;
                    r_part   <= n_part;
                    r_strict <= n_strict;
                    r_mod    <= n_mod;
                end
            end
        end
    end

endmodule

@@ design/u8dec_queue.sv @@
module u8dec_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  u8dec_pkg::t_job   i_job,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_empty,
    output u8dec_pkg::t_job   o_head
);
    import u8dec_pkg::*;

    t_job               r_mem [QueueDepth];
    logic [QueueAw-1:0] r_wr, r_rd;
    logic [QueueAw:0]   r_cnt;

    assign o_full  = (r_cnt == (QueueAw+1)'(QueueDepth));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_job;
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ design/u8dec_back.sv @@
module u8dec_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  u8dec_pkg::t_job   i_head,
    output logic              o_pop,
    u8dec_unit_if.source      o_unit
);
    import u8dec_pkg::*;

    logic        r_valid;
    logic        r_half;     // first unit of a pair already loaded
    logic [15:0] r_code;
    logic        r_present, r_end, r_ok, r_lastres;
    logic        w_load, w_first;

    assign w_load  = !i_empty && (!r_valid || o_unit.ready);
    assign w_first = i_head.two && !r_half;
    assign o_pop   = w_load && !w_first;

    assign o_unit.valid        = r_valid;
    assign o_unit.code_unit    = r_code;
    assign o_unit.unit_present = r_present;
    assign o_unit.string_end   = r_end;
    assign o_unit.string_ok    = r_ok;
    assign o_unit.last_result  = r_lastres;

    // output word register; a pair job leaves the queue after its second word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half  <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
            r_half  <= w_first;
        end else if (o_unit.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (w_first) begin
                r_code    <= i_head.unit0;
                r_present <= 1'b1;
                r_end     <= 1'b0;
                r_ok      <= 1'b0;
                r_lastres <= 1'b0;
            end else begin
                r_code    <= i_head.two ? i_head.unit1 : (i_head.has ? i_head.unit0 : '0);
                r_present <= i_head.two || i_head.has;
                r_end     <= i_head.last;
                r_ok      <= i_head.last && i_head.ok;
                r_lastres <= 1'b1;
            end
        end
    end

endmodule

@@ sim/tb_top.sv @@
module tb_top;
    import u8dec_pkg::*;

    localparam int CycleLimit   = 400000;
    localparam int PhaseBytes   = 382;
    localparam int CalmBytes    = 150;
    localparam int SettleCycles = 8;
    localparam int MaxPrinted   = 20;

    // code outside the named modes; the block treats it as "either form"
    localparam logic [1:0] ModeAlias = 2'd3;

    // one output word as the block presents it
    typedef struct packed {
        logic [15:0] code_unit;
        logic        unit_present;
        logic        string_end;
        logic        string_ok;
        logic        last_result;
    } t_unit_word;

    // Decoder state mirror plus the queue of words still owed by the block
    class unit_scoreboard;
        logic [1:0]  mode;
        logic [1:0]  cont_left;
        logic [7:0]  lead_byte;
        logic [20:0] scalar_bits;
        logic        strict_live;
        logic        modified_live;
        t_unit_word  owed_words[$];
        int          errors;

        function new();
            mode   = ModeEither;
            errors = 0;
            restart();
        endfunction

        function void restart();
            cont_left     = 2'd0;
            lead_byte     = 8'h00;
            scalar_bits   = 21'h0;
            strict_live   = (mode != ModeModified);
            modified_live = (mode != ModeStrict);
        endfunction

        function void set_mode(logic [1:0] m);
            mode = m;
        endfunction

        function int pending();
            return owed_words.size();
        endfunction

        // advance the mirror by one accepted byte and queue the words it owes
        function void decode_byte(logic [7:0] b, logic last);
            logic [15:0] units [2];
            logic [1:0]  cont_total;
            logic        second;
            logic        ok;
            logic [19:0] sup;
            int          n;
            int          items;
            t_unit_word  w;

            n  = 0;
            ok = 1'b0;
            if (mode == ModeModified) strict_live = 1'b0;
            if (mode == ModeStrict) modified_live = 1'b0;

            if (strict_live || modified_live) begin
                if (cont_left == 2'd0) begin
                    // lead position
                    if (b == 8'h00) begin
                        modified_live = 1'b0;
                        if (strict_live) begin
                            units[n] = 16'h0000;
                            n++;
                        end
                    end else if (b <= 8'h7F) begin
                        units[n] = {8'h00, b};
                        n++;
                    end else if (b == 8'hC0) begin
                        strict_live = 1'b0;
                        lead_byte   = b;
                        scalar_bits = 21'h0;
                        cont_left   = 2'd1;
                    end else if (b >= 8'hC2 && b <= 8'hDF) begin
                        lead_byte   = b;
                        scalar_bits = {16'h0, b[4:0]};
                        cont_left   = 2'd1;
                    end else if (b >= 8'hE0 && b <= 8'hEF) begin
                        lead_byte   = b;
                        scalar_bits = {17'h0, b[3:0]};
                        cont_left   = 2'd2;
                    end else if (b >= 8'hF0 && b <= 8'hF4) begin
                        modified_live = 1'b0;
                        lead_byte     = b;
                        scalar_bits   = {18'h0, b[2:0]};
                        cont_left     = 2'd3;
                    end else begin
                        strict_live   = 1'b0;
                        modified_live = 1'b0;
                    end
                end else begin
                    // continuation position
                    if (lead_byte < 8'hE0)      cont_total = 2'd1;
                    else if (lead_byte < 8'hF0) cont_total = 2'd2;
                    else                        cont_total = 2'd3;
                    second = (cont_left == cont_total);
                    if (b < 8'h80 || b > 8'hBF) begin
                        strict_live   = 1'b0;
                        modified_live = 1'b0;
                        cont_left     = 2'd0;
                    end else begin
                        if (lead_byte == 8'hC0 && b != 8'h80) modified_live = 1'b0;
                        if (second) begin
                            if (lead_byte == 8'hE0 && b < 8'hA0) begin
                                strict_live   = 1'b0;
                                modified_live = 1'b0;
                            end
                            if (lead_byte == 8'hED && b > 8'h9F) strict_live = 1'b0;
                            if (lead_byte == 8'hF0 && b < 8'h90) strict_live = 1'b0;
                            if (lead_byte == 8'hF4 && b > 8'h8F) strict_live = 1'b0;
                        end
                        scalar_bits = {scalar_bits[14:0], b[5:0]};
                        cont_left   = cont_left - 2'd1;
                        if (cont_left == 2'd0 && (strict_live || modified_live)) begin
                            if (lead_byte >= 8'hF0) begin
                                // supplementary scalar becomes a surrogate pair
                                sup      = scalar_bits[19:0] - 20'h10000;
                                units[0] = 16'hD800 + {6'h0, sup[19:10]};
                                units[1] = 16'hDC00 + {6'h0, sup[9:0]};
                                n        = 2;
                            end else begin
                                units[n] = scalar_bits[15:0];
                                n++;
                            end
                        end
                    end
                end
            end

            if (last) begin
                ok    = (strict_live || modified_live) && cont_left == 2'd0;
                items = (n == 0) ? 1 : n;
            end else begin
                items = n;
            end

            for (int k = 0; k < items; k++) begin
                w.code_unit    = (k < n) ? units[k] : 16'h0000;
                w.unit_present = (k < n);
                w.string_end   = last && (k == items - 1);
                w.string_ok    = last && (k == items - 1) && ok;
                w.last_result  = (k == items - 1);
                owed_words.insert(owed_words.size(), w);
            end

            if (last) restart();
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MaxPrinted) $display("ERROR: %s", msg);
        endtask

        // compare one delivered word with the oldest owed word
        task check_word(t_unit_word got);
            t_unit_word want;
            if (owed_words.size() == 0) begin
                report($sformatf("word %h with nothing owed", got));
                return;
            end
            want = owed_words.pop_front();
            if (got.code_unit !== want.code_unit)
                report($sformatf("code_unit %h, want %h", got.code_unit, want.code_unit));
            if (got.unit_present !== want.unit_present)
                report($sformatf("unit_present %b, want %b",
                                 got.unit_present, want.unit_present));
            if (got.string_end !== want.string_end)
                report($sformatf("string_end %b, want %b", got.string_end, want.string_end));
            if (got.string_ok !== want.string_ok)
                report($sformatf("string_ok %b, want %b", got.string_ok, want.string_ok));
            if (got.last_result !== want.last_result)
                report($sformatf("last_result %b, want %b",
                                 got.last_result, want.last_result));
        endtask
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       cfg_we;
    logic [1:0] cfg_data;

    u8dec_byte_if byte_ch ();
    u8dec_unit_if unit_ch ();

    utf8_mutf8_to_utf16_decoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte     (byte_ch),
        .o_unit     (unit_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    unit_scoreboard sb;
    logic [7:0]     str_bytes[$];
    bit             calm;        // no idling on either side
    bit             tx_bursts;
    bit             rx_bursts;
    int             cycles;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        cycles = 0;
        while (cycles < CycleLimit) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // output side: ready drops in random bursts
    initial begin : unit_sink
        int stall_left;
        int rx_cycle;
        stall_left    = 0;
        rx_cycle      = 0;
        rx_bursts     = 1'b1;
        unit_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rx_cycle++;
            if (rx_cycle % 64 == 0) rx_bursts = ($urandom_range(3, 0) != 0);
            if (stall_left > 0) begin
                stall_left--;
                unit_ch.ready <= 1'b0;
            end else if (!calm && rx_bursts && $urandom_range(5, 0) == 0) begin
                stall_left = $urandom_range(8, 1) - 1;
                unit_ch.ready <= 1'b0;
            end else begin
                unit_ch.ready <= 1'b1;
            end
        end
    end

    // output monitor
    initial begin : unit_monitor
        t_unit_word got;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && unit_ch.valid && unit_ch.ready) begin
                got.code_unit    = unit_ch.code_unit;
                got.unit_present = unit_ch.unit_present;
                got.string_end   = unit_ch.string_end;
                got.string_ok    = unit_ch.string_ok;
                got.last_result  = unit_ch.last_result;
                sb.check_word(got);
            end
        end
    end

    // one byte on the input channel, with an optional gap before it
    task automatic send_byte(logic [7:0] b, logic last);
        int gap;
        gap = 0;
        if (!calm && tx_bursts && $urandom_range(4, 0) == 0) gap = $urandom_range(8, 1);
        @(negedge i_clk);
        if (gap > 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        byte_ch.valid       <= 1'b1;
        byte_ch.data_byte   <= b;
        byte_ch.string_last <= last;
        @(posedge i_clk);
        while (!byte_ch.ready) @(posedge i_clk);
        sb.decode_byte(b, last);
    endtask

    // close marks the final byte as end of string
    task automatic send_string(logic close);
        foreach (str_bytes[i]) send_byte(str_bytes[i], close && (i == str_bytes.size() - 1));
    endtask

    // drop valid, drain owed words, then let the front end go quiet
    task automatic settle();
        @(negedge i_clk);
        byte_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_mode(logic [1:0] m);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_data <= m;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        sb.set_mode(m);
    endtask

    // add one byte to the tail of the string being built
    function automatic void append_byte(logic [7:0] b);
        str_bytes.insert(str_bytes.size(), b);
    endfunction

    function automatic logic [7:0] cont_byte();
        return 8'($urandom_range(8'hBF, 8'h80));
    endfunction

    // append one encoded piece; selectors above 15 are malformed or noise
    function automatic void add_piece(int sel);
        logic [7:0] lead;
        int         need;
        case (sel)
            0, 1, 2, 3, 4: append_byte(8'($urandom_range(127, 1)));
            5: append_byte(8'h00);
            6: begin
                append_byte(8'hC0);
                append_byte(8'h80);
            end
            7, 8: begin
                append_byte(8'($urandom_range(8'hDF, 8'hC2)));
                append_byte(cont_byte());
            end
            9: begin
                append_byte(8'hE0);
                append_byte(8'($urandom_range(8'hBF, 8'hA0)));
                append_byte(cont_byte());
            end
            10, 11: begin
                lead = 8'($urandom_range(8'hEE, 8'hE1));
                if (lead == 8'hED) lead = 8'hEF;
                append_byte(lead);
                append_byte(cont_byte());
                append_byte(cont_byte());
            end
            12: begin
                append_byte(8'hED);
                append_byte(8'($urandom_range(8'h9F, 8'h80)));
                append_byte(cont_byte());
            end
            13: begin
                // encoded surrogate
                append_byte(8'hED);
                append_byte(8'($urandom_range(8'hBF, 8'hA0)));
                append_byte(cont_byte());
            end
            14, 15: begin
                case ($urandom_range(2, 0))
                    0: begin
                        append_byte(8'hF0);
                        append_byte(8'($urandom_range(8'hBF, 8'h90)));
                    end
                    1: begin
                        append_byte(8'($urandom_range(8'hF3, 8'hF1)));
                        append_byte(cont_byte());
                    end
                    default: begin
                        append_byte(8'hF4);
                        append_byte(8'($urandom_range(8'h8F, 8'h80)));
                    end
                endcase
                append_byte(cont_byte());
                append_byte(cont_byte());
            end
            16: append_byte(8'($urandom_range(255, 0)));
            17: begin
                // sequence cut short
                lead = 8'($urandom_range(8'hF4, 8'hC2));
                need = (lead < 8'hE0) ? 1 : (lead < 8'hF0) ? 2 : 3;
                append_byte(lead);
                repeat ($urandom_range(need - 1, 0)) append_byte(cont_byte());
            end
            18: begin
                // overlong, out of range or never-valid leads
                case ($urandom_range(5, 0))
                    0: begin
                        append_byte(8'hC1);
                        append_byte(cont_byte());
                    end
                    1: begin
                        append_byte(8'hC0);
                        append_byte(8'($urandom_range(8'hBF, 8'h81)));
                    end
                    2: begin
                        append_byte(8'hE0);
                        append_byte(8'($urandom_range(8'h9F, 8'h80)));
                        append_byte(cont_byte());
                    end
                    3: begin
                        append_byte(8'hF0);
                        append_byte(8'($urandom_range(8'h8F, 8'h80)));
                        append_byte(cont_byte());
                        append_byte(cont_byte());
                    end
                    4: begin
                        append_byte(8'hF4);
                        append_byte(8'($urandom_range(8'hBF, 8'h90)));
                        append_byte(cont_byte());
                        append_byte(cont_byte());
                    end
                    default: append_byte(8'($urandom_range(8'hFF, 8'hF5)));
                endcase
            end
            default: append_byte(cont_byte());
        endcase
    endfunction

    // random strings, mostly well formed; optionally no idling at the tail
    task automatic run_phase(int nbytes, bit quiet_tail);
        int  sent;
        bit  clean;
        sent = 0;
        while (sent < nbytes) begin
            if (quiet_tail && sent >= nbytes - CalmBytes) calm = 1'b1;
            tx_bursts = ($urandom_range(3, 0) != 0);
            clean     = ($urandom_range(3, 0) != 0);
            str_bytes.delete();
            repeat ($urandom_range(6, 1))
                add_piece(clean ? $urandom_range(15, 0) : $urandom_range(19, 0));
            send_string(1'b1);
            sent += str_bytes.size();
        end
        settle();
    endtask

    initial begin : stimulus
        byte_ch.valid       = 1'b0;
        byte_ch.data_byte   = 8'h00;
        byte_ch.string_last = 1'b0;
        cfg_we              = 1'b0;
        cfg_data            = ModeEither;
        i_rst_n             = 1'b0;
        calm                = 1'b0;
        tx_bursts           = 1'b1;
        sb                  = new();

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed strings in the reset mode
        str_bytes = '{8'h00};                               // raw NUL, strict only
        send_string(1'b1);
        str_bytes = '{8'h7F, 8'hC0, 8'h80};                 // modified NUL ends the string
        send_string(1'b1);
        str_bytes = '{8'hF0, 8'h90, 8'h80, 8'h80};          // pair on the final byte
        send_string(1'b1);
        str_bytes = '{8'hED, 8'hA0, 8'h80, 8'hFF, 8'h41};   // surrogate, then both dead
        send_string(1'b1);
        str_bytes = '{8'hE2};                               // truncated
        send_string(1'b1);
        str_bytes = '{8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'hDF, 8'hBF};
        send_string(1'b1);

        // mode change with a sequence open
        str_bytes = '{8'hE2, 8'h82};
        send_string(1'b0);
        settle();
        write_mode(ModeStrict);
        str_bytes = '{8'hAC};
        send_string(1'b1);
        settle();

        run_phase(PhaseBytes, 1'b0);
        write_mode(ModeModified);
        run_phase(PhaseBytes, 1'b0);
        write_mode(ModeAlias);
        run_phase(PhaseBytes, 1'b0);
        write_mode(ModeEither);
        run_phase(PhaseBytes, 1'b1);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/u8dec_pkg.sv
design/u8dec_if.sv
design/u8dec_front.sv
design/u8dec_queue.sv
design/u8dec_back.sv
design/utf8_mutf8_to_utf16_decoder.sv
sim/tb_top.sv
